### sv/mtsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtsc_pkg
// Shared constants and types for the mining target and share check block.
// ----------------------------------------------------------------------------
package mtsc_pkg;

	localparam int unsigned WORD_W = 64;

	localparam logic [WORD_W-1:0] ALL_ONES_32 = 64'h0000_0000_FFFF_FFFF;
	localparam logic [WORD_W-1:0] ALL_ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;

	// operation codes
	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_CHECK   = 2'd1;
	localparam logic [1:0] OP_CONVERT = 2'd2;

	// target formats
	localparam logic [1:0] FMT_COMPACT = 2'd0;
	localparam logic [1:0] FMT_WORD64  = 2'd1;
	localparam logic [1:0] FMT_FULL256 = 2'd2;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage
`default_nettype wire

### sv/mtsc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtsc_div
// Radix-2 restoring divider, 64-bit by 64-bit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtsc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [mtsc_pkg::WORD_W-1:0]   dividend,
	input  wire logic [mtsc_pkg::WORD_W-1:0]   divisor,
	output mtsc_pkg::div_sts_t                 sts,
	output logic      [mtsc_pkg::WORD_W-1:0]   quotient
);
	import mtsc_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [WORD_W:0]   rem_sh;
	logic [WORD_W:0]   rem_sub;
	logic              fits;

	// shift in next dividend bit, trial subtract
	assign rem_sh  = {rem_q, quo_q[WORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign fits    = ~rem_sub[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> !sts.busy)
		else $error("divider done while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> sts.busy)
		else $error("divider did not go busy after start");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> $past(busy_q) && $past(cnt_q) == CNT_W'(WORD_W - 1))
		else $error("divider finished after wrong iteration count");

endmodule
`default_nettype wire

### sv/mining_target_and_share_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mining_target_and_share_check
// Share target store with compact/64-bit/256-bit target loading, share
// check against the target high word and difficulty-to-target conversion.
// ----------------------------------------------------------------------------
// One item at a time. A beat on the input is taken only while the sequencer
// is idle; the result beat sits in an output register, so the next input
// beat can be taken while that result still waits. All divisions run on one
// shared restoring divider. Check, unused op codes, convert of zero and loads
// of a zero/invalid target or of a 256-bit target with a zero high word use
// no division; a 64-bit or 256-bit target load and a convert of a nonzero
// difficulty run one division; a compact load chains three divisions.
// ----------------------------------------------------------------------------
module mining_target_and_share_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    operation,
	input  wire logic [1:0]                    target_format,
	input  wire logic [mtsc_pkg::WORD_W-1:0]   target_word0,
	input  wire logic [mtsc_pkg::WORD_W-1:0]   target_word1,
	input  wire logic [mtsc_pkg::WORD_W-1:0]   target_word2,
	input  wire logic [mtsc_pkg::WORD_W-1:0]   target_word3,
	input  wire logic [mtsc_pkg::WORD_W-1:0]   hash_high_word,
	input  wire logic [mtsc_pkg::WORD_W-1:0]   difficulty_in,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [mtsc_pkg::WORD_W-1:0]   difficulty_out,
	output logic      [mtsc_pkg::WORD_W-1:0]   result_word0,
	output logic      [mtsc_pkg::WORD_W-1:0]   result_word1,
	output logic      [mtsc_pkg::WORD_W-1:0]   result_word2,
	output logic      [mtsc_pkg::WORD_W-1:0]   result_word3,
	output logic                               share_valid
);
	import mtsc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_OUT
	} state_t;

	// what the running division computes
	typedef enum logic [1:0] {
		STEP_CDIFF,   // compact difficulty: (2^32-1) / compact
		STEP_T64,     // target high word: (2^64-1) / compact difficulty
		STEP_DIFF,    // stored difficulty: (2^64-1) / target high word
		STEP_CONV     // convert: (2^64-1) / difficulty_in
	} step_t;

	state_t            state_q;
	step_t             step_q;
	logic [1:0]        op_q;

	// stored target and difficulty
	logic [WORD_W-1:0] tw0_q, tw1_q, tw2_q, tw3_q;
	logic [WORD_W-1:0] diff_q;

	logic [WORD_W-1:0] conv_q;
	logic              share_q;

	// divider command
	logic              div_start_q;
	logic [WORD_W-1:0] div_a_q;
	logic [WORD_W-1:0] div_b_q;
	div_sts_t          div_sts;
	logic [WORD_W-1:0] div_quo;

	// output beat registers
	logic              out_valid_q;
	logic [WORD_W-1:0] out_diff_q;
	logic [WORD_W-1:0] out_w0_q, out_w1_q, out_w2_q, out_w3_q;
	logic              out_share_q;

	logic              in_fire;
	logic              out_free;
	logic [31:0]       compact;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	// compact zero is treated as one; bits above 31 ignored
	assign compact = (target_word0[31:0] == 32'd0) ? 32'd1 : target_word0[31:0];

	mtsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_DIFF;
			op_q        <= OP_LOAD;
			tw0_q       <= '0;
			tw1_q       <= '0;
			tw2_q       <= '0;
			tw3_q       <= '0;
			diff_q      <= '0;
			conv_q      <= '0;
			share_q     <= 1'b0;
			div_start_q <= 1'b0;
			div_a_q     <= '0;
			div_b_q     <= '0;
			out_valid_q <= 1'b0;
			out_diff_q  <= '0;
			out_w0_q    <= '0;
			out_w1_q    <= '0;
			out_w2_q    <= '0;
			out_w3_q    <= '0;
			out_share_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q    <= operation;
						share_q <= 1'b0;
						state_q <= S_OUT;
						priority if (operation == OP_LOAD) begin
							priority if (target_format == FMT_COMPACT) begin
								tw0_q       <= '0;
								tw1_q       <= '0;
								tw2_q       <= '0;
								div_a_q     <= ALL_ONES_32;
								div_b_q     <= {32'd0, compact};
								div_start_q <= 1'b1;
								step_q      <= STEP_CDIFF;
								state_q     <= S_DIV;
							end else if (target_format == FMT_WORD64) begin
								tw0_q <= '0;
								tw1_q <= '0;
								tw2_q <= '0;
								tw3_q <= target_word0;
								if (target_word0 == '0) begin
									diff_q <= '0;
								end else begin
									div_a_q     <= ALL_ONES_64;
									div_b_q     <= target_word0;
									div_start_q <= 1'b1;
									step_q      <= STEP_DIFF;
									state_q     <= S_DIV;
								end
							end else if (target_format == FMT_FULL256) begin
								tw0_q <= target_word0;
								tw1_q <= target_word1;
								tw2_q <= target_word2;
								tw3_q <= target_word3;
								if (target_word3 == '0) begin
									diff_q <= WORD_W'(1);
								end else begin
									div_a_q     <= ALL_ONES_64;
									div_b_q     <= target_word3;
									div_start_q <= 1'b1;
									step_q      <= STEP_DIFF;
									state_q     <= S_DIV;
								end
							end else begin
								// invalid format: unusable target
								tw0_q  <= '0;
								tw1_q  <= '0;
								tw2_q  <= '0;
								tw3_q  <= '0;
								diff_q <= '0;
							end
						end else if (operation == OP_CHECK) begin
							share_q <= (diff_q != '0) && (tw3_q != '0) &&
								(hash_high_word <= tw3_q);
						end else if (operation == OP_CONVERT) begin
							if (difficulty_in == '0) begin
								conv_q <= '0;
							end else begin
								div_a_q     <= ALL_ONES_64;
								div_b_q     <= difficulty_in;
								div_start_q <= 1'b1;
								step_q      <= STEP_CONV;
								state_q     <= S_DIV;
							end
						end else begin
							// unused op code reports state only
						end
					end
				end

				S_DIV: begin
					if (div_sts.done) begin
						unique case (step_q)
							STEP_CDIFF: begin
								div_a_q     <= ALL_ONES_64;
								div_b_q     <= div_quo;
								div_start_q <= 1'b1;
								step_q      <= STEP_T64;
							end
							STEP_T64: begin
								tw3_q       <= div_quo;
								div_a_q     <= ALL_ONES_64;
								div_b_q     <= div_quo;
								div_start_q <= 1'b1;
								step_q      <= STEP_DIFF;
							end
							STEP_DIFF: begin
								diff_q  <= div_quo;
								state_q <= S_OUT;
							end
							STEP_CONV: begin
								conv_q  <= div_quo;
								state_q <= S_OUT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end

				S_OUT: begin
					// hand the result to the output register once it is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_diff_q  <= diff_q;
						out_share_q <= share_q;
						if (op_q == OP_CONVERT) begin
							out_w0_q <= '0;
							out_w1_q <= '0;
							out_w2_q <= '0;
							out_w3_q <= conv_q;
						end else begin
							out_w0_q <= tw0_q;
							out_w1_q <= tw1_q;
							out_w2_q <= tw2_q;
							out_w3_q <= tw3_q;
						end
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign difficulty_out = out_diff_q;
	assign result_word0   = out_w0_q;
	assign result_word1   = out_w1_q;
	assign result_word2   = out_w2_q;
	assign result_word3   = out_w3_q;
	assign share_valid    = out_share_q;

	// divider only started when idle
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> !div_sts.busy)
		else $error("divider started while busy");

	// an accepted share always has a usable target behind it
	a_share_usable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && share_valid |-> difficulty_out != '0 && result_word3 != '0)
		else $error("share accepted against unusable target");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken while an item is in flight");

	// divider completes only while sequencer waits on it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == S_DIV)
		else $error("divider result arrived outside division state");

endmodule
`default_nettype wire

### test/mining_target_and_share_check_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mining_target_and_share_check_test
// Drives load, check, convert and unused-op beats through the block under
// random idling and back-pressure. A local predictor tracks the stored target
// and difficulty and scores every result beat field by field, in order.
// ----------------------------------------------------------------------------
module mining_target_and_share_check_test;

	import mtsc_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] FMT_INVALID = 2'd3;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned SETTLE_CYCLES = 250;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct {
		logic [1:0] op;
		logic [1:0] fmt;
		word_t      w0;
		word_t      w1;
		word_t      w2;
		word_t      w3;
		word_t      hash;
		word_t      diff;
	} share_job_t;

	typedef struct {
		word_t diff;
		word_t r0;
		word_t r1;
		word_t r2;
		word_t r3;
		logic  share;
	} target_report_t;

	logic clk = 1'b0;
	logic arst_n;

	logic       in_valid;
	logic       in_ready;
	logic [1:0] operation;
	logic [1:0] target_format;
	word_t      target_word0;
	word_t      target_word1;
	word_t      target_word2;
	word_t      target_word3;
	word_t      hash_high_word;
	word_t      difficulty_in;

	logic  out_valid;
	logic  out_ready;
	word_t difficulty_out;
	word_t result_word0;
	word_t result_word1;
	word_t result_word2;
	word_t result_word3;
	logic  share_valid;

	// predictor state: mirrors the block's stored target and difficulty
	word_t tgt_words [4];
	word_t tgt_difficulty;

	target_report_t target_reports_due [$];

	bit          idling_on = 1'b1;
	int unsigned hold_off_left = 0;
	int unsigned cycle_count = 0;
	int unsigned failures = 0;
	int unsigned reports_checked = 0;
	int unsigned n_loads = 0;
	int unsigned n_compact = 0;
	int unsigned n_checks = 0;
	int unsigned n_shares_ok = 0;
	int unsigned n_converts = 0;
	int unsigned n_unused = 0;

	mining_target_and_share_check u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.target_format  (target_format),
		.target_word0   (target_word0),
		.target_word1   (target_word1),
		.target_word2   (target_word2),
		.target_word3   (target_word3),
		.hash_high_word (hash_high_word),
		.difficulty_in  (difficulty_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.difficulty_out (difficulty_out),
		.result_word0   (result_word0),
		.result_word1   (result_word1),
		.result_word2   (result_word2),
		.result_word3   (result_word3),
		.share_valid    (share_valid)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic void store_target(word_t a, word_t b, word_t c, word_t d, word_t diff);
		tgt_words[0] = a;
		tgt_words[1] = b;
		tgt_words[2] = c;
		tgt_words[3] = d;
		tgt_difficulty = diff;
	endfunction

	// Applies one accepted beat to the mirrored state and returns its result.
	function automatic target_report_t predict_target_report(share_job_t job);
		target_report_t rep;
		word_t compact;
		word_t cdiff;
		word_t t64;

		rep.share = 1'b0;
		if (job.op == OP_LOAD) begin
			case (job.fmt)
				FMT_COMPACT: begin
					// only the low 32 bits count; zero behaves as one
					compact = job.w0 & ALL_ONES_32;
					if (compact == '0)
						compact = 1;
					cdiff = ALL_ONES_32 / compact;
					t64 = ALL_ONES_64 / cdiff;
					store_target('0, '0, '0, t64, ALL_ONES_64 / t64);
				end
				FMT_WORD64: begin
					if (job.w0 == '0)
						store_target('0, '0, '0, '0, '0);
					else
						store_target('0, '0, '0, job.w0, ALL_ONES_64 / job.w0);
				end
				FMT_FULL256: begin
					// zero high word still stores the words; difficulty becomes 1
					store_target(job.w0, job.w1, job.w2, job.w3,
						(job.w3 != '0) ? ALL_ONES_64 / job.w3 : word_t'(1));
				end
				default: store_target('0, '0, '0, '0, '0);
			endcase
		end else if (job.op == OP_CHECK) begin
			// equality passes; unusable target never passes
			rep.share = (tgt_difficulty != '0) && (tgt_words[3] != '0) &&
				(job.hash <= tgt_words[3]);
		end

		rep.diff = tgt_difficulty;
		if (job.op == OP_CONVERT) begin
			rep.r0 = '0;
			rep.r1 = '0;
			rep.r2 = '0;
			rep.r3 = (job.diff != '0) ? ALL_ONES_64 / job.diff : '0;
		end else begin
			rep.r0 = tgt_words[0];
			rep.r1 = tgt_words[1];
			rep.r2 = tgt_words[2];
			rep.r3 = tgt_words[3];
		end
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Mix of edge values and full-range random words.
	function automatic word_t wide_value();
		case ($urandom_range(7))
			0: return '0;
			1: return ALL_ONES_64;
			2: return word_t'($urandom_range(1, 16));
			3: return word_t'(1) << $urandom_range(63);
			4: return {32'h0, 32'($urandom)};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Every field random; callers then pin the ones that matter.
	function automatic share_job_t noise_job(logic [1:0] op);
		share_job_t job;

		job.op = op;
		job.fmt = 2'($urandom);
		job.w0 = wide_value();
		job.w1 = wide_value();
		job.w2 = wide_value();
		job.w3 = wide_value();
		job.hash = wide_value();
		job.diff = wide_value();
		return job;
	endfunction

	function automatic share_job_t load_job(logic [1:0] fmt, word_t a, word_t b, word_t c,
			word_t d);
		share_job_t job;

		job = noise_job(OP_LOAD);
		job.fmt = fmt;
		job.w0 = a;
		job.w1 = b;
		job.w2 = c;
		job.w3 = d;
		return job;
	endfunction

	function automatic share_job_t check_job(word_t hash);
		share_job_t job;

		job = noise_job(OP_CHECK);
		job.hash = hash;
		return job;
	endfunction

	function automatic share_job_t convert_job(word_t diff);
		share_job_t job;

		job = noise_job(OP_CONVERT);
		job.diff = diff;
		return job;
	endfunction

	// Offers one beat; returns once it has been accepted.
	task automatic send_job(share_job_t job);
		@(negedge clk);
		while (idling_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation      <= job.op;
		target_format  <= job.fmt;
		target_word0   <= job.w0;
		target_word1   <= job.w1;
		target_word2   <= job.w2;
		target_word3   <= job.w3;
		hash_high_word <= job.hash;
		difficulty_in  <= job.diff;
		in_valid       <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);

		target_reports_due.push_back(predict_target_report(job));
		case (job.op)
			OP_LOAD: begin
				n_loads++;
				if (job.fmt == FMT_COMPACT)
					n_compact++;
			end
			OP_CHECK: n_checks++;
			OP_CONVERT: n_converts++;
			default: n_unused++;
		endcase
	endtask

	// Sender goes quiet until every outstanding result has been seen.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (target_reports_due.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Fresh target is all zero: a check must fail, op 3 just reports state.
	task automatic test_reset_state();
		send_job(check_job('0));
		send_job(noise_job(OP_UNUSED));
	endtask

	task automatic test_conversions();
		send_job(convert_job('0));
		send_job(convert_job(word_t'(1)));
		send_job(convert_job(word_t'(2)));
		send_job(convert_job(ALL_ONES_64));
	endtask

	// Upper 32 bits of word 0 must be ignored; compact zero acts as one.
	task automatic test_compact_loads();
		send_job(load_job(FMT_COMPACT, ALL_ONES_64, '0, '0, '0));
		send_job(load_job(FMT_COMPACT, 64'hFFFF_FFFF_0000_0000, '0, '0, '0));
		send_job(load_job(FMT_COMPACT, word_t'(1), '0, '0, '0));
		send_job(load_job(FMT_COMPACT, 64'hA5A5_5A5A_0000_FFFF, wide_value(),
			wide_value(), wide_value()));
	endtask

	// Hash at, just above and far below the stored high word.
	task automatic test_share_checks();
		send_job(check_job(tgt_words[3]));
		send_job(check_job(tgt_words[3] + 1));
		send_job(check_job('0));
	endtask

	task automatic test_wide_loads();
		// zero 64-bit target: unusable
		send_job(load_job(FMT_WORD64, '0, '0, '0, '0));
		send_job(check_job('0));
		send_job(load_job(FMT_WORD64, ALL_ONES_64, '0, '0, '0));
		send_job(check_job(ALL_ONES_64));
		send_job(load_job(FMT_WORD64, word_t'(1), '0, '0, '0));
		// 256-bit with zero high word: words kept, difficulty 1, checks fail
		send_job(load_job(FMT_FULL256, ALL_ONES_64, ALL_ONES_64, ALL_ONES_64, '0));
		send_job(check_job('0));
		send_job(load_job(FMT_FULL256, ALL_ONES_64, ALL_ONES_64, ALL_ONES_64, ALL_ONES_64));
		// invalid format clears everything
		send_job(load_job(FMT_INVALID, ALL_ONES_64, ALL_ONES_64, ALL_ONES_64, ALL_ONES_64));
		send_job(check_job('0));
		send_job(noise_job(OP_UNUSED));
	endtask

	// Receiver stalls for a long stretch while beats keep coming; the block
	// backs up into its input. Then the sender waits for a full drain.
	task automatic test_backpressure();
		send_job(load_job(FMT_COMPACT, 64'h0000_0000_1D00_FFFF, '0, '0, '0));
		hold_off_left = 400;
		send_job(check_job(tgt_words[3]));
		send_job(convert_job(wide_value()));
		send_job(load_job(FMT_WORD64, wide_value(), '0, '0, '0));
		send_job(check_job(wide_value()));
		send_job(noise_job(OP_UNUSED));
		send_job(check_job(tgt_words[3] - 1));
		wait_for_results();
	endtask

	// Random mix of loads, checks near the stored target, conversions and unused ops.
	task automatic test_random_traffic(int unsigned count, bit with_idling);
		share_job_t job;
		int unsigned pick;

		idling_on = with_idling;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				job = noise_job(OP_LOAD);
				pick = $urandom_range(99);
				job.fmt = (pick < 30) ? FMT_COMPACT : (pick < 55) ? FMT_WORD64 :
					(pick < 90) ? FMT_FULL256 : FMT_INVALID;
			end else if (pick < 65) begin
				job = noise_job(OP_CHECK);
				case ($urandom_range(3))
					0: job.hash = tgt_words[3];
					1: job.hash = tgt_words[3] + 1;
					2: job.hash = tgt_words[3] - 1;
					default: job.hash = wide_value();
				endcase
			end else if (pick < 93) begin
				job = noise_job(OP_CONVERT);
			end else begin
				job = noise_job(OP_UNUSED);
			end
			send_job(job);
		end
		idling_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------
	// Ready with random stalls, or held low while a hold-off is counting down.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !idling_on || $urandom_range(99) >= 31;
			end
		end
	end

	task automatic compare_field(string name, word_t want, word_t got);
		if (want !== got) begin
			$error("%s: expected 0x%016h, got 0x%016h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : score_results
		target_report_t want;

		if (arst_n && out_valid && out_ready) begin
			if (target_reports_due.size() == 0) begin
				$error("result beat with nothing outstanding");
				failures++;
			end else begin
				want = target_reports_due.pop_front();
				compare_field("difficulty_out", want.diff, difficulty_out);
				compare_field("result_word0", want.r0, result_word0);
				compare_field("result_word1", want.r1, result_word1);
				compare_field("result_word2", want.r2, result_word2);
				compare_field("result_word3", want.r3, result_word3);
				compare_field("share_valid", word_t'(want.share), word_t'(share_valid));
				if (want.share)
					n_shares_ok++;
				reports_checked++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_LOAD;
		target_format = FMT_COMPACT;
		target_word0 = '0;
		target_word1 = '0;
		target_word2 = '0;
		target_word3 = '0;
		hash_high_word = '0;
		difficulty_in = '0;
		store_target('0, '0, '0, '0, '0);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_conversions();
		test_compact_loads();
		test_share_checks();
		test_wide_loads();
		test_backpressure();
		test_random_traffic(600, 1'b1);
		test_random_traffic(300, 1'b0);
		test_random_traffic(1000, 1'b1);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (target_reports_due.size() != 0) begin
			$error("%0d results never arrived", target_reports_due.size());
			failures++;
		end

		$display("covered %0d loads (%0d compact), %0d share checks (%0d met target),",
			n_loads, n_compact, n_checks, n_shares_ok);
		$display("%0d conversions, %0d unused-op beats; %0d results scored, %0d mismatches",
			n_converts, n_unused, reports_checked, failures);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
